// ===== rtl/div64su_pkg.sv =====
// Shared types and constants for the 64-bit signed/unsigned divider.
package div64su_pkg;

  // Fixed width of the operand and result ports.
  localparam int FIELD_W = 64;

  typedef logic [FIELD_W-1:0] field_t;

  // Command codes.
  localparam logic CMD_UNSIGNED = 1'b0;
  localparam logic CMD_SIGNED   = 1'b1;

endpackage

// ===== rtl/divider_64bit_signed_unsigned.sv =====
// Top level: iterative restoring divider, unsigned or signed two's complement.
//
// Input channel in_*: command (0 unsigned, 1 signed), dividend and divisor.
// A beat is taken when in_valid is high and in_stall is low. Only the low
// DATA_WIDTH bits of each operand are used. Result channel out_*: quotient,
// remainder (sign of the dividend in signed mode) and divide_by_zero. The
// result bits above DATA_WIDTH are zero. A zero divisor gives the flag with
// zero quotient and remainder.
// Operation: magnitudes load on the input beat, then DATA_WIDTH passes
// through the single shared subtract-and-compare unit (one quotient bit per
// cycle), then the sign fix-up into the output register, which sets out_valid.
// Flow: no new item is taken until the current one has left the fix-up step;
// in_stall is high while an item is in the shared unit or the fix-up step.
// A new item is taken while an earlier result still waits in the output
// register. If the receiver stalls, the result holds in the output register
// and the fix-up step waits for it to drain.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops any
// pending result.
module divider_64bit_signed_unsigned #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic [div64su_pkg::FIELD_W-1:0]    in_dividend,
  input  logic [div64su_pkg::FIELD_W-1:0]    in_divisor,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [div64su_pkg::FIELD_W-1:0]    out_quotient,
  output logic [div64su_pkg::FIELD_W-1:0]    out_remainder,
  output logic                               out_divide_by_zero
);

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     den_r, den_nxt;
  logic             neg_q_r, neg_q_nxt;
  logic             neg_r_r, neg_r_nxt;
  logic             dbz_r, dbz_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [div64su_pkg::FIELD_W-1:0] out_quo_r, out_quo_nxt;
  logic [div64su_pkg::FIELD_W-1:0] out_rem_r, out_rem_nxt;
  logic                            out_dbz_r, out_dbz_nxt;

  logic [W-1:0] num_in, den_in;
  logic         num_neg, den_neg, in_signed;
  logic         in_acc, out_free;
  logic [W:0]   rem_sh, diff;
  logic         fits;
  logic [W-1:0] q_fin, r_fin;

  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  assign num_in    = in_dividend[W-1:0];
  assign den_in    = in_divisor[W-1:0];
  assign in_signed = (in_command == div64su_pkg::CMD_SIGNED);
  assign num_neg   = in_signed && num_in[W-1];
  assign den_neg   = in_signed && den_in[W-1];

  // Shared unit: bring down the next dividend bit and try the subtract.
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = !diff[W];

  assign q_fin = neg_q_r ? (~quo_r + W'(1)) : quo_r;
  assign r_fin = neg_r_r ? (~rem_r + W'(1)) : rem_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    den_nxt       = den_r;
    neg_q_nxt     = neg_q_r;
    neg_r_nxt     = neg_r_r;
    dbz_nxt       = dbz_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_quo_nxt   = out_quo_r;
    out_rem_nxt   = out_rem_r;
    out_dbz_nxt   = out_dbz_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rem_nxt   = '0;
          quo_nxt   = num_neg ? (~num_in + W'(1)) : num_in;
          den_nxt   = den_neg ? (~den_in + W'(1)) : den_in;
          neg_q_nxt = num_neg != den_neg;
          neg_r_nxt = num_neg;
          dbz_nxt   = (den_in == '0);
          cnt_nxt   = CNT_LAST;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        rem_nxt = fits ? diff[W-1:0] : rem_sh[W-1:0];
        quo_nxt = {quo_r[W-2:0], fits};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dbz_nxt   = dbz_r;
          out_quo_nxt   = dbz_r ? '0 : div64su_pkg::FIELD_W'(q_fin);
          out_rem_nxt   = dbz_r ? '0 : div64su_pkg::FIELD_W'(r_fin);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    den_r     <= den_nxt;
    neg_q_r   <= neg_q_nxt;
    neg_r_r   <= neg_r_nxt;
    dbz_r     <= dbz_nxt;
    out_quo_r <= out_quo_nxt;
    out_rem_r <= out_rem_nxt;
    out_dbz_r <= out_dbz_nxt;
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_quotient       = out_quo_r;
  assign out_remainder      = out_rem_r;
  assign out_divide_by_zero = out_dbz_r;

endmodule

// ===== rtl/div64su_checker.sv =====
// Port-level checker for the divider, bound to the top level.
module div64su_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [div64su_pkg::FIELD_W-1:0] out_quotient,
  input logic [div64su_pkg::FIELD_W-1:0] out_remainder,
  input logic                            out_divide_by_zero
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_quotient) &&
      $stable(out_remainder) && $stable(out_divide_by_zero))
    else $error("result beat changed while stalled");

  // Zero divisor gives zero quotient and remainder.
  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_quotient == '0 && out_remainder == '0)
    else $error("divide-by-zero result not cleared");

  // An accepted beat keeps the unit busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input taken again while unit busy");

  // A fresh result only comes out of the fix-up step, while busy.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in flight");

endmodule

bind divider_64bit_signed_unsigned div64su_checker u_div64su_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_quotient       (out_quotient),
  .out_remainder      (out_remainder),
  .out_divide_by_zero (out_divide_by_zero)
);
